// File: design/wwgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwgs_pkg
// Shared types and constants of the wireworld grid step engine.
// ----------------------------------------------------------------------------
package wwgs_pkg;

  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 32;

  // fixed widths of the item fields
  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 2;
  localparam int OP_W   = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_RUN_ENABLE = 1'b0;

  typedef enum logic [CELL_W-1:0] {
    CELL_EMPTY = 2'd0,
    CELL_WIRE  = 2'd1,
    CELL_HEAD  = 2'd2,
    CELL_TAIL  = 2'd3
  } cell_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP
  } state_t;

endpackage : wwgs_pkg
`default_nettype wire

// File: design/wireworld_grid_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wireworld_grid_step_top
// Wireworld engine over two banks of 2-bit cells: cell write, cell read and
// one-generation step (a plain copy while run_enable is low) with cursor edits.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel (valid/stall) carries one op per item: write cell, read cell
//   or step one generation. out_* channel returns one read_state per item,
//   zero for anything but a read. run_enable sits at APB address 0.
//   Write and unused ops load their result in the cycle after they are
//   taken; a read goes through the bank's registered read port, then into
//   the result register in ST_READ. A step keeps the block busy while the
//   live bank is scanned through its single read port, one cell a cycle,
//   into a shift line of two rows plus three cells, and one shared neighbor
//   count and rule unit produces one new cell a cycle, then the result.
//   One item is in work at a time; in_stall is high until it finishes.
//   After reset both banks are swept to empty, one address a cycle over
//   2**(clog2(rows)+clog2(cols)) addresses (2048 for 64x32) with in_stall high;
//   APB writes are taken during the sweep.
//   While out_stall holds a result, a new item is taken only as the result
//   leaves, so results never overtake or overwrite each other.
// ----------------------------------------------------------------------------
module wireworld_grid_step_top
  import wwgs_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_opcode,
  input  wire logic [COL_W-1:0]      in_col,
  input  wire logic [ROW_W-1:0]      in_row,
  input  wire logic [CELL_W-1:0]     in_cell_value,
  input  wire logic                  in_edit_wire,
  input  wire logic                  in_edit_electron,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CELL_W-1:0]          out_read_state,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CW      = $clog2(GRID_COLS);
  localparam int RW      = $clog2(GRID_ROWS);
  localparam int RRW     = $clog2(GRID_ROWS + 2);
  localparam int AW      = RW + CW;
  localparam int DEPTH   = 1 << AW;
  localparam int NCELL   = GRID_COLS * GRID_ROWS;
  localparam int LAST_RD = NCELL + GRID_COLS;
  localparam int FIRST_C = GRID_COLS + 3;
  localparam int CNTW    = $clog2(NCELL + GRID_COLS + 3);
  localparam int SRL     = 2 * GRID_COLS + 3;

  state_t state_r, state_nxt;

  logic              bank_sel_r;
  logic              run_enable_r;
  logic              out_valid_r;
  cell_t             out_state_r;
  logic              rd_inside_r;
  logic [AW-1:0]     clr_r;

  // step sequencer
  logic [CNTW-1:0]   cnt_r;
  logic [CW-1:0]     rc_r;
  logic [RRW-1:0]    rr_r;
  logic [CW-1:0]     cc_r;
  logic [RW-1:0]     cr_r;
  logic              s1_v_r;
  logic              s1_in_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic              wire_r;
  logic              elec_r;
  cell_t             sr_r [SRL];

  // ram ports
  logic              we0, we1;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rd0, rd1;
  cell_t             live_rd;

  logic              in_acc;
  logic              in_inside;
  logic [AW-1:0]     in_addr;
  logic [31:0]       col_ext, row_ext;
  logic              comp_v;
  logic              step_done;
  logic              ld_zero, ld_read;
  cell_t             center, next_cell;
  logic [7:0]        nb;
  logic [3:0]        heads;
  logic              at_cursor;
  logic              cfg_wr;

  // ---------------------------------------------------------------------------
  // grid banks
  // ---------------------------------------------------------------------------
  wwgs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd0)
  );

  wwgs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd1)
  );

  assign live_rd = cell_t'(bank_sel_r ? rd1 : rd0);

  // ---------------------------------------------------------------------------
  // item decode
  // ---------------------------------------------------------------------------
  assign col_ext   = 32'(in_col);
  assign row_ext   = 32'(in_row);
  assign in_inside = (col_ext < 32'(GRID_COLS)) && (row_ext < 32'(GRID_ROWS));
  assign in_addr   = {row_ext[RW-1:0], col_ext[CW-1:0]};

  assign in_stall = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // shared evaluate unit: one cell of the new generation a cycle
  // ---------------------------------------------------------------------------
  assign comp_v    = (state_r == ST_STEP) && (cnt_r >= CNTW'(FIRST_C));
  assign step_done = comp_v && (cc_r == CW'(GRID_COLS - 1)) && (cr_r == RW'(GRID_ROWS - 1));

  always_comb begin
    logic top_ok, bot_ok, lft_ok, rgt_ok;
    cell_t evolved;
    top_ok = (cr_r != '0);
    bot_ok = (cr_r != RW'(GRID_ROWS - 1));
    lft_ok = (cc_r != '0);
    rgt_ok = (cc_r != CW'(GRID_COLS - 1));
    center = sr_r[GRID_COLS + 1];
    // newest cell sits at tap 0, the center one tap past one row
    nb[0] = top_ok && lft_ok && (sr_r[2*GRID_COLS + 2] == CELL_HEAD);
    nb[1] = top_ok &&           (sr_r[2*GRID_COLS + 1] == CELL_HEAD);
    nb[2] = top_ok && rgt_ok && (sr_r[2*GRID_COLS]     == CELL_HEAD);
    nb[3] =           lft_ok && (sr_r[GRID_COLS + 2]   == CELL_HEAD);
    nb[4] =           rgt_ok && (sr_r[GRID_COLS]       == CELL_HEAD);
    nb[5] = bot_ok && lft_ok && (sr_r[2]               == CELL_HEAD);
    nb[6] = bot_ok &&           (sr_r[1]               == CELL_HEAD);
    nb[7] = bot_ok && rgt_ok && (sr_r[0]               == CELL_HEAD);
    heads = 4'($countones(nb));
    case (center)
      CELL_HEAD: evolved = CELL_TAIL;
      CELL_TAIL: evolved = CELL_WIRE;
      CELL_WIRE: evolved = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_WIRE;
      default:   evolved = CELL_EMPTY;
    endcase
    at_cursor = (32'(cc_r) == 32'(cur_col_r)) && (32'(cr_r) == 32'(cur_row_r));
    if (at_cursor && wire_r) begin
      next_cell = (center == CELL_EMPTY) ? CELL_WIRE : CELL_EMPTY;
    end else if (at_cursor && elec_r) begin
      next_cell = (center == CELL_HEAD) ? CELL_WIRE : CELL_HEAD;
    end else if (run_enable_r) begin
      next_cell = evolved;
    end else begin
      next_cell = center;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    we0       = 1'b0;
    we1       = 1'b0;
    waddr     = in_addr;
    wdata     = in_cell_value;
    raddr     = in_addr;
    ld_zero   = 1'b0;
    ld_read   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        we0   = 1'b1;
        we1   = 1'b1;
        waddr = clr_r;
        wdata = CELL_EMPTY;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_opcode))
            OP_WRITE: begin
              we0     = in_inside && !bank_sel_r;
              we1     = in_inside && bank_sel_r;
              ld_zero = 1'b1;
            end
            OP_READ:  state_nxt = ST_READ;
            OP_STEP:  state_nxt = ST_STEP;
            default:  ld_zero = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        ld_read   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        raddr = {rr_r[RW-1:0], rc_r};
        waddr = {cr_r, cc_r};
        wdata = next_cell;
        we0   = comp_v && bank_sel_r;
        we1   = comp_v && !bank_sel_r;
        if (step_done) begin
          ld_zero   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r   <= 1'b0;
      run_enable_r <= 1'b1;
      out_valid_r  <= 1'b0;
      clr_r        <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_RUN_ENABLE)) begin
        run_enable_r <= pwdata[0];
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (step_done) begin
        bank_sel_r <= !bank_sel_r;
      end
      if (ld_zero || ld_read) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      s1_v_r <= (state_r == ST_STEP) && (cnt_r <= CNTW'(LAST_RD));
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld_zero) begin
      out_state_r <= CELL_EMPTY;
    end else if (ld_read) begin
      out_state_r <= rd_inside_r ? live_rd : CELL_EMPTY;
    end
    if (in_acc) begin
      rd_inside_r <= in_inside;
      cur_col_r   <= in_col;
      cur_row_r   <= in_row;
      wire_r      <= in_edit_wire;
      elec_r      <= in_edit_electron;
      cnt_r       <= '0;
      rc_r        <= '0;
      rr_r        <= '0;
      cc_r        <= '0;
      cr_r        <= '0;
    end else if (state_r == ST_STEP) begin
      cnt_r <= cnt_r + CNTW'(1);
      // scan the live bank in raster order, rows past the end read as empty
      if (cnt_r <= CNTW'(LAST_RD)) begin
        if (rc_r == CW'(GRID_COLS - 1)) begin
          rc_r <= '0;
          rr_r <= rr_r + RRW'(1);
        end else begin
          rc_r <= rc_r + CW'(1);
        end
      end
      if (comp_v) begin
        if (cc_r == CW'(GRID_COLS - 1)) begin
          cc_r <= '0;
          cr_r <= cr_r + RW'(1);
        end else begin
          cc_r <= cc_r + CW'(1);
        end
      end
    end
    s1_in_r <= (rr_r < RRW'(GRID_ROWS));
    if (s1_v_r) begin
      sr_r[0] <= s1_in_r ? live_rd : CELL_EMPTY;
      for (int i = 1; i < SRL; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_state = out_state_r;
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == REG_RUN_ENABLE) ?
                          {{(CFG_DATA_W-1){1'b0}}, run_enable_r} : '0;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("item taken while busy");

  a_live_bank_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> !(bank_sel_r ? we1 : we0))
    else $error("step wrote into the live bank");

  a_flip_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_sel_r != $past(bank_sel_r)) |-> ($past(state_r) == ST_STEP))
    else $error("bank flipped outside a step");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_zero || ld_read) |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

endmodule : wireworld_grid_step_top
`default_nettype wire

// File: design/wwgs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwgs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wwgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule : wwgs_ram
`default_nettype wire
